@@ sv/semq_pkg.sv @@
// Shared constants, codes and types for the semaphore table with wait queues.
`default_nettype none

package semq_pkg;

    // Table geometry
    localparam int NUM_SEMS    = 16;
    localparam int QUEUE_DEPTH = 16;

    localparam int SEM_W    = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;
    localparam int QPTR_W   = $clog2(QUEUE_DEPTH);
    localparam int FILL_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int MADDR_W  = SEM_W + QPTR_W;
    localparam int MEM_DEPTH = 2 ** MADDR_W;

    // Field widths of the item channels
    localparam int ACTION_W = 2;
    localparam int PID_W    = 8;
    localparam int SEMID_W  = 4;
    localparam int INIT_W   = 15;
    localparam int STATUS_W = 3;
    localparam int SLOT_W   = 4;
    localparam int COUNT_W  = 16;

    // Command queue between front and back
    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    // Action codes on the request channel
    localparam logic [ACTION_W-1:0] ACT_ALLOC  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_WAIT   = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_SIGNAL = 2'd2;

    // Status codes on the response channel
    localparam logic [STATUS_W-1:0] ST_ALLOC      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NONE_FREE  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_WAIT_PASS  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_WAIT_BLOCK = 3'd3;
    localparam logic [STATUS_W-1:0] ST_SIG_NOWAKE = 3'd4;
    localparam logic [STATUS_W-1:0] ST_SIG_WAKE   = 3'd5;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW   = 3'd6;

    typedef logic signed [COUNT_W-1:0] count_t;

    localparam count_t COUNT_MAX = {1'b0, {(COUNT_W-1){1'b1}}};
    localparam count_t COUNT_MIN = {1'b1, {(COUNT_W-1){1'b0}}};

    // Decoded operation
    typedef enum logic [1:0] {
        OP_ALLOC,
        OP_WAIT,
        OP_SIGNAL,
        OP_NONE
    } op_t;

    // Classified command as queued for the back end
    typedef struct packed {
        op_t                op;
        logic [PID_W-1:0]   pid;
        logic [SEM_W-1:0]   sem;
        logic [INIT_W-1:0]  init;
    } cmd_t;

    // Handshake between front end and command queue
    typedef struct packed {
        logic push;
        cmd_t cmd;
    } push_t;

endpackage

`default_nettype wire

@@ sv/semq_if.sv @@
// Request and response channel interfaces of the semaphore table.
`default_nettype none

interface semq_req_if;
    logic                          valid;
    logic                          ready;
    logic [semq_pkg::ACTION_W-1:0] action;
    logic [semq_pkg::PID_W-1:0]    proc_id;
    logic [semq_pkg::SEMID_W-1:0]  sem_id;
    logic [semq_pkg::INIT_W-1:0]   init_value;

    modport source (output valid, action, proc_id, sem_id, init_value, input ready);
    modport sink   (input valid, action, proc_id, sem_id, init_value, output ready);
endinterface

interface semq_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [semq_pkg::STATUS_W-1:0] status;
    logic [semq_pkg::SLOT_W-1:0]   slot;
    logic [semq_pkg::PID_W-1:0]    wake_pid;

    modport source (output valid, status, slot, wake_pid, input ready);
    modport sink   (input valid, status, slot, wake_pid, output ready);
endinterface

`default_nettype wire

@@ sv/semq_front.sv @@
// Front end: accept request items and classify them into queued commands.
`default_nettype none

module semq_front (
    semq_req_if.sink          req,
    input  wire logic         q_full,
    output semq_pkg::push_t   q_push
);
    import semq_pkg::*;

    op_t op;

    // Decode the action code
    always_comb
    begin
        unique case (req.action)
            ACT_ALLOC:  op = OP_ALLOC;
            ACT_WAIT:   op = OP_WAIT;
            ACT_SIGNAL: op = OP_SIGNAL;
            default:    op = OP_NONE;
        endcase
    end

    assign req.ready = !q_full;

    // Reduce the slot index into the table and build the command
    always_comb
    begin
        q_push.push     = req.valid && !q_full;
        q_push.cmd.op   = op;
        q_push.cmd.pid  = req.proc_id;
        q_push.cmd.sem  = SEM_W'(32'(req.sem_id) % NUM_SEMS);
        q_push.cmd.init = req.init_value;
    end

endmodule

`default_nettype wire

@@ sv/semq_cmd_fifo.sv @@
// Short command queue that decouples the front end from the back end.
`default_nettype none

module semq_cmd_fifo (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire semq_pkg::push_t q_push,
    output logic                 full,
    input  wire logic            pop,
    output semq_pkg::cmd_t       pop_cmd,
    output logic                 empty
);
    import semq_pkg::*;

    cmd_t                  entry_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [FIFO_CNT_W-1:0] count_reg;
    logic [FIFO_PTR_W-1:0] wr_ptr_next;
    logic [FIFO_PTR_W-1:0] rd_ptr_next;
    logic [FIFO_CNT_W-1:0] count_next;

    assign full    = (count_reg == FIFO_CNT_W'(FIFO_DEPTH));
    assign empty   = (count_reg == '0);
    assign pop_cmd = entry_reg[rd_ptr_reg];

    // Advance pointers with wrap and track the fill
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (q_push.push)
        begin
            wr_ptr_next = (wr_ptr_reg == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (q_push.push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !q_push.push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Hold the queued commands
    always_ff @(posedge clk)
    begin
        if (q_push.push)
        begin
            entry_reg[wr_ptr_reg] <= q_push.cmd;
        end
    end

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> count_reg != '0)
        else $error("command queue popped while empty");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_push.push |-> count_reg != FIFO_CNT_W'(FIFO_DEPTH))
        else $error("command queue pushed while full");

endmodule

`default_nettype wire

@@ sv/semq_back.sv @@
// Back end: slot table, waiter memory and execution of commands in a read state and an exec state.
`default_nettype none

module semq_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           empty,
    input  wire semq_pkg::cmd_t pop_cmd,
    output logic                pop,
    semq_rsp_if.source          rsp
);
    import semq_pkg::*;

    typedef enum logic {
        S_READ,
        S_EXEC
    } state_t;

    state_t                state_reg;
    logic                  rsp_valid_reg;
    logic [STATUS_W-1:0]   status_reg;
    logic [SLOT_W-1:0]     slot_reg;
    logic [PID_W-1:0]      pid_reg;

    // Per-slot table
    logic                  valid_reg [NUM_SEMS];
    count_t                count_reg [NUM_SEMS];
    logic [QPTR_W-1:0]     head_reg  [NUM_SEMS];
    logic [QPTR_W-1:0]     tail_reg  [NUM_SEMS];
    logic [FILL_W-1:0]     fill_reg  [NUM_SEMS];

    // Waiter memory, one row of QUEUE_DEPTH entries per slot
    logic [PID_W-1:0]      waiter_mem [MEM_DEPTH];
    logic [PID_W-1:0]      mem_rd_reg;

    // Command and slot state latched in the read cycle
    cmd_t                  cmd_reg;
    count_t                count_rd_reg;
    logic [QPTR_W-1:0]     head_rd_reg;
    logic [QPTR_W-1:0]     tail_rd_reg;
    logic [FILL_W-1:0]     fill_rd_reg;

    // Execution results
    logic                  start;
    logic                  free_found;
    logic [SEM_W-1:0]      free_idx;
    count_t                dec_count;
    count_t                inc_count;
    logic                  wr_en;
    logic                  valid_set;
    logic                  mem_we;
    logic [SEM_W-1:0]      wr_sem;
    count_t                count_new;
    logic [QPTR_W-1:0]     head_new;
    logic [QPTR_W-1:0]     tail_new;
    logic [FILL_W-1:0]     fill_new;
    logic [STATUS_W-1:0]   status_next;
    logic [SLOT_W-1:0]     slot_next;
    logic [PID_W-1:0]      pid_next;

    // Take a command once the response register is free by the exec cycle
    assign start = (state_reg == S_READ) && !empty && (!rsp_valid_reg || rsp.ready);
    assign pop   = start;

    assign rsp.valid    = rsp_valid_reg;
    assign rsp.status   = status_reg;
    assign rsp.slot     = slot_reg;
    assign rsp.wake_pid = pid_reg;

    // Read cycle: latch command and addressed slot state
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            cmd_reg      <= pop_cmd;
            count_rd_reg <= count_reg[pop_cmd.sem];
            head_rd_reg  <= head_reg[pop_cmd.sem];
            tail_rd_reg  <= tail_reg[pop_cmd.sem];
            fill_rd_reg  <= fill_reg[pop_cmd.sem];
        end
    end

    // Waiter memory: read the oldest waiter, write a new one at the tail
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mem_rd_reg <= waiter_mem[{pop_cmd.sem, head_reg[pop_cmd.sem]}];
        end
        if (mem_we)
        begin
            waiter_mem[{cmd_reg.sem, tail_rd_reg}] <= cmd_reg.pid;
        end
    end

    // Find the lowest free slot
    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = NUM_SEMS - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = SEM_W'(i);
            end
        end
    end

    // Saturating count steps
    assign dec_count = (count_rd_reg == COUNT_MIN) ? COUNT_MIN : count_rd_reg - count_t'(1);
    assign inc_count = (count_rd_reg == COUNT_MAX) ? COUNT_MAX : count_rd_reg + count_t'(1);

    // Exec cycle: carry out the command
    always_comb
    begin
        status_next = ST_NONE_FREE;
        slot_next   = '0;
        pid_next    = '0;
        wr_en       = 1'b0;
        valid_set   = 1'b0;
        mem_we      = 1'b0;
        wr_sem      = cmd_reg.sem;
        count_new   = count_rd_reg;
        head_new    = head_rd_reg;
        tail_new    = tail_rd_reg;
        fill_new    = fill_rd_reg;
        unique case (cmd_reg.op)
            OP_ALLOC:
            begin
                if (free_found)
                begin
                    status_next = ST_ALLOC;
                    slot_next   = SLOT_W'(free_idx);
                    wr_en       = 1'b1;
                    valid_set   = 1'b1;
                    wr_sem      = free_idx;
                    count_new   = count_t'(cmd_reg.init);
                    head_new    = '0;
                    tail_new    = '0;
                    fill_new    = '0;
                end
            end
            OP_WAIT:
            begin
                slot_next = SLOT_W'(cmd_reg.sem);
                if (!dec_count[COUNT_W-1])
                begin
                    status_next = ST_WAIT_PASS;
                    wr_en       = 1'b1;
                    count_new   = dec_count;
                end
                else if (fill_rd_reg >= FILL_W'(QUEUE_DEPTH))
                begin
                    status_next = ST_OVERFLOW;
                end
                else
                begin
                    status_next = ST_WAIT_BLOCK;
                    wr_en       = 1'b1;
                    mem_we      = 1'b1;
                    count_new   = dec_count;
                    tail_new    = (tail_rd_reg == QPTR_W'(QUEUE_DEPTH - 1)) ?
                                  '0 : tail_rd_reg + 1'b1;
                    fill_new    = fill_rd_reg + 1'b1;
                end
            end
            OP_SIGNAL:
            begin
                slot_next = SLOT_W'(cmd_reg.sem);
                wr_en     = 1'b1;
                count_new = inc_count;
                if (inc_count > count_t'(0) || fill_rd_reg == '0)
                begin
                    status_next = ST_SIG_NOWAKE;
                end
                else
                begin
                    status_next = ST_SIG_WAKE;
                    pid_next    = mem_rd_reg;
                    head_new    = (head_rd_reg == QPTR_W'(QUEUE_DEPTH - 1)) ?
                                  '0 : head_rd_reg + 1'b1;
                    fill_new    = fill_rd_reg - 1'b1;
                end
            end
            OP_NONE:
            begin
                status_next = ST_NONE_FREE;
            end
            default:
            begin
                status_next = ST_NONE_FREE;
            end
        endcase
        if (state_reg != S_EXEC)
        begin
            wr_en  = 1'b0;
            mem_we = 1'b0;
        end
    end

    // Update the slot table
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '{default: 1'b0};
            count_reg <= '{default: '0};
            head_reg  <= '{default: '0};
            tail_reg  <= '{default: '0};
            fill_reg  <= '{default: '0};
        end
        else if (wr_en)
        begin
            count_reg[wr_sem] <= count_new;
            head_reg[wr_sem]  <= head_new;
            tail_reg[wr_sem]  <= tail_new;
            fill_reg[wr_sem]  <= fill_new;
            if (valid_set)
            begin
                valid_reg[wr_sem] <= 1'b1;
            end
        end
    end

    // Sequencer and response register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_READ;
            rsp_valid_reg <= 1'b0;
            status_reg    <= '0;
            slot_reg      <= '0;
            pid_reg       <= '0;
        end
        else
        begin
            if (rsp_valid_reg && rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_READ:
                begin
                    if (start)
                    begin
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    state_reg     <= S_READ;
                    rsp_valid_reg <= 1'b1;
                    status_reg    <= status_next;
                    slot_reg      <= slot_next;
                    pid_reg       <= pid_next;
                end
                default:
                begin
                    state_reg <= S_READ;
                end
            endcase
        end
    end

    a_exec_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_EXEC |=> state_reg == S_READ)
        else $error("exec cycle did not return to read");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_EXEC |-> fill_rd_reg <= FILL_W'(QUEUE_DEPTH))
        else $error("wait queue fill beyond its depth");

    a_rsp_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == S_EXEC))
        else $error("response raised outside an exec cycle");

endmodule

`default_nettype wire

@@ sv/semaphore_table_with_wait_queues.sv @@
// Top level of the counting-semaphore table with per-slot FIFO wait queues.
//
// Usage: requests arrive on req (valid/ready; action, proc_id, sem_id,
// init_value) and each one gives exactly one item on rsp (valid/ready;
// status, slot, wake_pid), in request order.
// The front end classifies each request and places it in a two-entry
// command queue; req.ready is low only while that queue is full.
// The back end takes one command at a time: a read cycle that fetches the
// slot state and the oldest waiter from the waiter memory, then an exec
// cycle that updates the slot and writes the response register.
// The back end completes the exec cycle of one command before it takes
// another, so the read and exec cycles of two commands never overlap.
// When rsp stalls, the response register holds; the back end starts no new
// command until that register is taken, and the queue then absorbs up to
// two requests before req.ready drops.
// Reset (rst_n low, asynchronous) frees every slot, clears counts and queue
// pointers and empties the command queue; waiter memory is not cleared.
`default_nettype none

module semaphore_table_with_wait_queues (
    input  wire logic  clk,
    input  wire logic  rst_n,
    semq_req_if.sink   req,
    semq_rsp_if.source rsp
);
    import semq_pkg::*;

    push_t q_push;
    logic  q_full;
    logic  q_empty;
    logic  q_pop;
    cmd_t  q_cmd;

    semq_front u_front (
        .req    (req),
        .q_full (q_full),
        .q_push (q_push)
    );

    semq_cmd_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_push  (q_push),
        .full    (q_full),
        .pop     (q_pop),
        .pop_cmd (q_cmd),
        .empty   (q_empty)
    );

    semq_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .empty   (q_empty),
        .pop_cmd (q_cmd),
        .pop     (q_pop),
        .rsp     (rsp)
    );

endmodule

`default_nettype wire
